/* rtl/rsc_pkg.sv */
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and constants for the ray-sphere closest hit unit
// Payload words, multiply-accumulate micro-op table and datapath widths.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int INDEX_BITS_DEF = 16;

  localparam int COORD_W = 32;
  localparam int RAD_W   = 31;
  localparam int IDX_W   = 16;

  localparam int CO_W   = COORD_W + 1;
  localparam int A_W    = 64;
  localparam int B_W    = 66;
  localparam int C_W    = 67;
  localparam int D_W    = 134;
  localparam int SQ_W   = D_W / 2;
  localparam int NUM_W  = SQ_W + 2;
  localparam int MAG_W  = NUM_W - 1;
  localparam int QUO_W  = 32;

  localparam int LIMB_W = 34;
  localparam int OPND_W = 2 * LIMB_W;
  localparam int ACC_W  = 4 * LIMB_W;
  localparam int CSUB_W = 72;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 2'd1;

  localparam logic signed [COORD_W-1:0] RANGE_MIN_RST = 32'sd66;
  localparam logic signed [COORD_W-1:0] DIST_MAX      = 32'sh7FFF_FFFF;
  localparam logic [QUO_W-1:0]          POS_LIM       = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0]          NEG_LIM       = 32'h8000_0000;

  localparam int UOP_CNT_W = 4;
  localparam logic [UOP_CNT_W-1:0] UOP_LAST = 4'd11;

  typedef enum logic [3:0] {
    OPND_DX, OPND_DY, OPND_DZ, OPND_COX, OPND_COY, OPND_COZ,
    OPND_RAD, OPND_A, OPND_B, OPND_C
  } opnd_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_A, DST_B, DST_C, DST_D
  } dst_e;

  typedef struct packed {
    opnd_e x;
    opnd_e y;
    logic  sub;
    logic  wide;
    logic  clr;
    dst_e  dst;
  } uop_t;

  typedef struct packed {
    logic       en;
    logic       clr;
    logic       sub;
    logic [1:0] limb;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RAD_W-1:0]          sphere_radius;
    logic [IDX_W-1:0]          shape_index;
    logic                      new_ray;
  } in_item_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] root_plus;
    logic signed [COORD_W-1:0] root_minus;
    logic                      closest_valid;
    logic [IDX_W-1:0]          closest_index;
    logic signed [COORD_W-1:0] closest_dist;
  } out_item_t;

  // A = d.d, B = co.d, C = co.co - r*r, D = B*B - A*C
  function automatic uop_t uop_at(input logic [UOP_CNT_W-1:0] step);
    uop_t u;
    u = '{x: OPND_DX, y: OPND_DX, sub: 1'b0, wide: 1'b0, clr: 1'b0, dst: DST_NONE};
    unique case (step)
      4'd0:  begin u.x = OPND_DX;  u.y = OPND_DX;  u.clr = 1'b1; end
      4'd1:  begin u.x = OPND_DY;  u.y = OPND_DY;  end
      4'd2:  begin u.x = OPND_DZ;  u.y = OPND_DZ;  u.dst = DST_A; end
      4'd3:  begin u.x = OPND_COX; u.y = OPND_DX;  u.clr = 1'b1; end
      4'd4:  begin u.x = OPND_COY; u.y = OPND_DY;  end
      4'd5:  begin u.x = OPND_COZ; u.y = OPND_DZ;  u.dst = DST_B; end
      4'd6:  begin u.x = OPND_COX; u.y = OPND_COX; u.clr = 1'b1; end
      4'd7:  begin u.x = OPND_COY; u.y = OPND_COY; end
      4'd8:  begin u.x = OPND_COZ; u.y = OPND_COZ; end
      4'd9:  begin u.x = OPND_RAD; u.y = OPND_RAD; u.sub = 1'b1; u.dst = DST_C; end
      4'd10: begin u.x = OPND_B;   u.y = OPND_B;   u.wide = 1'b1; u.clr = 1'b1; end
      4'd11: begin
        u.x = OPND_A; u.y = OPND_C; u.wide = 1'b1; u.sub = 1'b1; u.dst = DST_D;
      end
      default: u.dst = DST_NONE;
    endcase
    return u;
  endfunction

endpackage

/* rtl/rsc_if.sv */
// ----------------------------------------------------------------------------
// rsc_if: valid/ready channels of the ray-sphere closest hit unit
// One channel carries ray and sphere words in, the other result words out.
// ----------------------------------------------------------------------------
interface rsc_in_if;
  logic               valid;
  logic               ready;
  rsc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rsc_out_if;
  logic               valid;
  logic               ready;
  rsc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rsc_mac.sv */
// ----------------------------------------------------------------------------
// rsc_mac: shared multiply-accumulate unit
// One 34x34 limb product per cycle, signed by magnitude, added into an
// accumulator at a limb offset.
// ----------------------------------------------------------------------------
module rsc_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rsc_pkg::mac_ctl_t                    ctl_i,
  input  logic signed [rsc_pkg::OPND_W-1:0]    opa_i,
  input  logic signed [rsc_pkg::OPND_W-1:0]    opb_i,
  output logic signed [rsc_pkg::ACC_W-1:0]     sum_o
);
  import rsc_pkg::*;

  logic [OPND_W-1:0]   mag_a, mag_b;
  logic [LIMB_W-1:0]   limb_a, limb_b;
  logic [2*LIMB_W-1:0] prod;
  logic [ACC_W-1:0]    term, base;
  logic                neg;
  logic [ACC_W-1:0]    acc_q;

  always_comb begin
    mag_a  = opa_i[OPND_W-1] ? OPND_W'(-opa_i) : OPND_W'(opa_i);
    mag_b  = opb_i[OPND_W-1] ? OPND_W'(-opb_i) : OPND_W'(opb_i);
    limb_a = ctl_i.limb[1] ? mag_a[2*LIMB_W-1:LIMB_W] : mag_a[LIMB_W-1:0];
    limb_b = ctl_i.limb[0] ? mag_b[2*LIMB_W-1:LIMB_W] : mag_b[LIMB_W-1:0];
    prod   = limb_a * limb_b;
    unique case (ctl_i.limb)
      2'd0:    term = ACC_W'(prod);
      2'd1,
      2'd2:    term = ACC_W'(prod) << LIMB_W;
      default: term = ACC_W'(prod) << (2 * LIMB_W);
    endcase
    neg   = opa_i[OPND_W-1] ^ opb_i[OPND_W-1] ^ ctl_i.sub;
    base  = ctl_i.clr ? '0 : acc_q;
    sum_o = $signed(base + (neg ? -term : term));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.en) begin
      acc_q <= sum_o;
    end
  end

endmodule

/* rtl/rsc_csub.sv */
// ----------------------------------------------------------------------------
// rsc_csub: shared compare-subtract unit
// Serves the square root and the restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module rsc_csub (
  input  logic [rsc_pkg::CSUB_W-1:0] a_i,
  input  logic [rsc_pkg::CSUB_W-1:0] b_i,
  output logic [rsc_pkg::CSUB_W-1:0] diff_o,
  output logic                       ge_o
);
  import rsc_pkg::*;

  logic [CSUB_W:0] wide_diff;

  always_comb begin
    wide_diff = {1'b0, a_i} - {1'b0, b_i};
    diff_o    = wide_diff[CSUB_W-1:0];
    ge_o      = !wide_diff[CSUB_W];
  end

endmodule

/* rtl/ray_sphere_closest_hit_unit.sv */
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit_unit: ray-sphere intersection with closest hit record
// Solves the quadratic per sphere and tracks the nearest in-range root.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one ray and one sphere per word; out_o returns one result
//   word per input word. Both are valid/ready channels. cfg_we_i writes
//   range_min (index 0) or range_max (index 1); the user must write them
//   only while the unit is idle, and the unit itself does not enforce it.
//   On a miss the square root and the division are skipped, and a root
//   that saturates skips its division. One shared 34x34 multiplier builds
//   A, B, C and D; one shared 72-bit compare-subtract unit then serves the
//   square root and, for each root, the division before its range test.
//   One item is in flight at a time: in_i.ready is high only while idle,
//   so the unit takes no new word until it is through with the last one.
//   A result waiting on out_o does not block acceptance of the next word;
//   if the receiver still stalls when that item finishes, the unit holds
//   it until out_o is free.
//   Reset empties the output, sets range_min to 66, range_max and the
//   closest distance to the largest value, and clears the record.
// ----------------------------------------------------------------------------
module ray_sphere_closest_hit_unit #(
  parameter int FRAC_BITS  = rsc_pkg::FRAC_BITS_DEF,
  parameter int INDEX_BITS = rsc_pkg::INDEX_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  rsc_in_if.sink                             in_i,
  rsc_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import rsc_pkg::*;

  localparam int IDXW = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam int M_W  = MAG_W + FRAC_BITS;
  localparam int CNT_W = 7;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MAC    = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_SQRT   = 4'd3;
  localparam logic [3:0] S_NUM    = 4'd4;
  localparam logic [3:0] S_DIVCHK = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_UPD    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // control state
  logic [3:0]                state_q, state_d;
  logic [UOP_CNT_W-1:0]      step_q, step_d;
  logic [1:0]                limb_q, limb_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      pass_q, pass_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [COORD_W-1:0] rmin_q, rmin_d, rmax_q, rmax_d;
  logic signed [COORD_W-1:0] best_dist_q, best_dist_d;
  logic [IDXW-1:0]           best_idx_q, best_idx_d;
  logic                      best_valid_q, best_valid_d;

  // datapath
  logic signed [CO_W-1:0]    co_q [3], co_d [3];
  logic signed [COORD_W-1:0] dir_q [3], dir_d [3];
  logic [RAD_W-1:0]          rad_q, rad_d;
  logic [IDXW-1:0]           idx_q, idx_d;
  logic [A_W-1:0]            a_q, a_d;
  logic signed [B_W-1:0]     b_q, b_d;
  logic signed [C_W-1:0]     c_q, c_d;
  logic signed [D_W-1:0]     d_q, d_d;
  logic [SQ_W-1:0]           root_q, root_d;
  logic [CSUB_W-1:0]         rem_q, rem_d;
  logic [QUO_W-1:0]          lo_q, lo_d, quo_q, quo_d;
  logic                      neg_q, neg_d, ovf_q, ovf_d, hit_q, hit_d;
  logic signed [COORD_W-1:0] rp_q, rp_d, rm_q, rm_d;
  out_item_t                 out_q, out_d;

  uop_t                      uop;
  mac_ctl_t                  mac_ctl;
  logic signed [OPND_W-1:0]  opa, opb;
  logic signed [ACC_W-1:0]   mac_sum;
  logic [CSUB_W-1:0]         cs_a, cs_b, cs_diff;
  logic                      cs_ge;

  logic signed [NUM_W-1:0]   nb, s_ext, num;
  logic [MAG_W-1:0]          num_mag;
  logic [M_W-1:0]            m_val;
  logic [QUO_W-1:0]          lim, rmag;
  logic signed [COORD_W-1:0] rval;

  function automatic logic signed [OPND_W-1:0] opnd_val(input opnd_e sel);
    logic signed [OPND_W-1:0] v;
    unique case (sel)
      OPND_DX:  v = OPND_W'(dir_q[0]);
      OPND_DY:  v = OPND_W'(dir_q[1]);
      OPND_DZ:  v = OPND_W'(dir_q[2]);
      OPND_COX: v = OPND_W'(co_q[0]);
      OPND_COY: v = OPND_W'(co_q[1]);
      OPND_COZ: v = OPND_W'(co_q[2]);
      OPND_RAD: v = $signed(OPND_W'(rad_q));
      OPND_A:   v = $signed(OPND_W'(a_q));
      OPND_B:   v = OPND_W'(b_q);
      OPND_C:   v = OPND_W'(c_q);
      default:  v = '0;
    endcase
    return v;
  endfunction

  rsc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .opa_i  (opa),
    .opb_i  (opb),
    .sum_o  (mac_sum)
  );

  rsc_csub u_csub (
    .a_i    (cs_a),
    .b_i    (cs_b),
    .diff_o (cs_diff),
    .ge_o   (cs_ge)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    uop = uop_at(step_q);
    opa = opnd_val(uop.x);
    opb = opnd_val(uop.y);

    nb      = -NUM_W'(b_q);
    s_ext   = $signed(NUM_W'(root_q));
    num     = pass_q ? (nb - s_ext) : (nb + s_ext);
    num_mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    m_val   = {num_mag, {FRAC_BITS{1'b0}}};

    lim  = neg_q ? NEG_LIM : POS_LIM;
    rmag = (ovf_q || (quo_q > lim)) ? lim : quo_q;
    rval = neg_q ? $signed(-rmag) : $signed(rmag);

    state_d      = state_q;
    step_d       = step_q;
    limb_d       = limb_q;
    cnt_d        = cnt_q;
    pass_d       = pass_q;
    out_valid_d  = out_valid_q;
    rmin_d       = rmin_q;
    rmax_d       = rmax_q;
    best_dist_d  = best_dist_q;
    best_idx_d   = best_idx_q;
    best_valid_d = best_valid_q;
    co_d         = co_q;
    dir_d        = dir_q;
    rad_d        = rad_q;
    idx_d        = idx_q;
    a_d          = a_q;
    b_d          = b_q;
    c_d          = c_q;
    d_d          = d_q;
    root_d       = root_q;
    rem_d        = rem_q;
    lo_d         = lo_q;
    quo_d        = quo_q;
    neg_d        = neg_q;
    ovf_d        = ovf_q;
    hit_d        = hit_q;
    rp_d         = rp_q;
    rm_d         = rm_q;
    out_d        = out_q;
    mac_ctl      = '0;
    cs_a         = {rem_q[CSUB_W-2:0], lo_q[QUO_W-1]};
    cs_b         = CSUB_W'(a_q);

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RANGE_MIN: rmin_d = $signed(cfg_wdata_i);
        CFG_RANGE_MAX: rmax_d = $signed(cfg_wdata_i);
        default: ;
      endcase
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          co_d[0]  = {in_i.data.origin_x[COORD_W-1], in_i.data.origin_x}
                   - {in_i.data.center_x[COORD_W-1], in_i.data.center_x};
          co_d[1]  = {in_i.data.origin_y[COORD_W-1], in_i.data.origin_y}
                   - {in_i.data.center_y[COORD_W-1], in_i.data.center_y};
          co_d[2]  = {in_i.data.origin_z[COORD_W-1], in_i.data.origin_z}
                   - {in_i.data.center_z[COORD_W-1], in_i.data.center_z};
          dir_d[0] = in_i.data.dir_x;
          dir_d[1] = in_i.data.dir_y;
          dir_d[2] = in_i.data.dir_z;
          rad_d    = in_i.data.sphere_radius;
          idx_d    = in_i.data.shape_index[IDXW-1:0];
          if (in_i.data.new_ray) begin
            best_dist_d  = DIST_MAX;
            best_idx_d   = '0;
            best_valid_d = 1'b0;
          end
          step_d  = '0;
          limb_d  = '0;
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        mac_ctl.en   = 1'b1;
        mac_ctl.clr  = uop.clr && (limb_q == 2'd0);
        mac_ctl.sub  = uop.sub;
        mac_ctl.limb = uop.wide ? limb_q : 2'd0;
        if (!uop.wide || (limb_q == 2'd3)) begin
          unique case (uop.dst)
            DST_A:   a_d = mac_sum[A_W-1:0];
            DST_B:   b_d = mac_sum[B_W-1:0];
            DST_C:   c_d = mac_sum[C_W-1:0];
            DST_D:   d_d = mac_sum[D_W-1:0];
            default: ;
          endcase
          limb_d = '0;
          if (step_q == UOP_LAST) begin
            state_d = S_CHK;
          end else begin
            step_d = step_q + 1'b1;
          end
        end else begin
          limb_d = limb_q + 1'b1;
        end
      end
      S_CHK: begin
        hit_d   = (a_q != '0) && !d_q[D_W-1];
        rp_d    = '0;
        rm_d    = '0;
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        pass_d  = 1'b0;
        state_d = ((a_q != '0) && !d_q[D_W-1]) ? S_SQRT : S_DONE;
      end
      S_SQRT: begin
        cs_a  = {rem_q[CSUB_W-3:0], d_q[D_W-1 -: 2]};
        cs_b  = CSUB_W'({root_q, 2'b01});
        if (cs_ge) begin
          rem_d  = cs_diff;
          root_d = {root_q[SQ_W-2:0], 1'b1};
        end else begin
          rem_d  = cs_a;
          root_d = {root_q[SQ_W-2:0], 1'b0};
        end
        d_d   = d_q <<< 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQ_W - 1)) begin
          state_d = S_NUM;
        end
      end
      S_NUM: begin
        neg_d   = num[NUM_W-1];
        rem_d   = CSUB_W'(m_val[M_W-1:QUO_W]);
        lo_d    = m_val[QUO_W-1:0];
        state_d = S_DIVCHK;
      end
      S_DIVCHK: begin
        cs_a    = rem_q;
        ovf_d   = cs_ge;
        quo_d   = '0;
        cnt_d   = '0;
        state_d = cs_ge ? S_UPD : S_DIV;
      end
      S_DIV: begin
        lo_d = lo_q << 1;
        if (cs_ge) begin
          rem_d = cs_diff;
          quo_d = {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_d = cs_a;
          quo_d = {quo_q[QUO_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (pass_q) begin
          rm_d = rval;
        end else begin
          rp_d = rval;
        end
        if ((rval > rmin_q) && (rval < rmax_q) && (rval < best_dist_q)) begin
          best_dist_d  = rval;
          best_idx_d   = idx_q;
          best_valid_d = 1'b1;
        end
        if (pass_q) begin
          state_d = S_DONE;
        end else begin
          pass_d  = 1'b1;
          state_d = S_NUM;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.hit           = hit_q;
          out_d.root_plus     = rp_q;
          out_d.root_minus    = rm_q;
          out_d.closest_valid = best_valid_q;
          out_d.closest_index = IDX_W'(best_idx_q);
          out_d.closest_dist  = best_dist_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      limb_q       <= '0;
      cnt_q        <= '0;
      pass_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      rmin_q       <= RANGE_MIN_RST;
      rmax_q       <= DIST_MAX;
      best_dist_q  <= DIST_MAX;
      best_idx_q   <= '0;
      best_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      limb_q       <= limb_d;
      cnt_q        <= cnt_d;
      pass_q       <= pass_d;
      out_valid_q  <= out_valid_d;
      rmin_q       <= rmin_d;
      rmax_q       <= rmax_d;
      best_dist_q  <= best_dist_d;
      best_idx_q   <= best_idx_d;
      best_valid_q <= best_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    co_q   <= co_d;
    dir_q  <= dir_d;
    rad_q  <= rad_d;
    idx_q  <= idx_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
    root_q <= root_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    ovf_q  <= ovf_d;
    hit_q  <= hit_d;
    rp_q   <= rp_d;
    rm_q   <= rm_d;
    out_q  <= out_d;
  end

endmodule

/* rtl/rsc_checker.sv */
// ----------------------------------------------------------------------------
// rsc_checker: port-level checks for the ray-sphere closest hit unit
// Bound to the top level; watches the channels only.
// ----------------------------------------------------------------------------
module rsc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input rsc_pkg::out_item_t                   out_data_i
);
  import rsc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.hit |->
      (out_data_i.root_plus == '0) && (out_data_i.root_minus == '0))
    else $error("roots nonzero on a miss");

  a_empty_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.closest_valid |->
      (out_data_i.closest_dist == DIST_MAX) && (out_data_i.closest_index == '0))
    else $error("empty record not at its cleared value");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready while an item is in flight");

endmodule

bind ray_sphere_closest_hit_unit rsc_checker u_rsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
